// File: src/sie_pkg.sv
// ---------------------------------------------------------------------------
// sie_pkg
// Shared constants and types for the stress invariant evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
package sie_pkg;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 6;
    localparam int SHIFT     = FRAC_BITS + 1;
    localparam int ROOT_BITS = 32;

    localparam logic [1:0]  DIM_2D    = 2'd2;
    localparam logic [1:0]  DIM_RESET = 2'd3;
    // ceil(2^36 / 3), exact floor division by three for values below 2^34
    localparam logic [34:0] RECIP3    = 35'h555555556;

    typedef struct packed {
        logic signed [31:0] pressure;
        logic signed [47:0] energy;
        logic               sat;
    } sie_payload_t;
endpackage
`default_nettype wire

// File: src/sie_lane.sv
// ---------------------------------------------------------------------------
// sie_lane
// One component lane: stress times strain product and weighted square.
// ---------------------------------------------------------------------------
`default_nettype none
module sie_lane (
    input  wire logic               aclk,
    input  wire logic               adv,
    input  wire logic signed [31:0] stress,
    input  wire logic signed [31:0] strain,
    input  wire logic signed [32:0] sq_op,
    input  wire logic               heavy,
    output logic signed [63:0]      prod,
    output logic        [66:0]      wsq
);
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod2_reg;
    logic        [63:0] sq_reg;
    logic               heavy_reg;
    logic        [66:0] wsq_reg;
    logic        [32:0] mag;

    assign mag = sq_op[32] ? 33'(-sq_op) : 33'(sq_op);

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= stress * strain;
            sq_reg    <= 64'(mag * mag);
            heavy_reg <= heavy;
            prod2_reg <= prod_reg;
            wsq_reg   <= heavy_reg ? ({1'b0, sq_reg, 2'b00} + {2'b00, sq_reg, 1'b0})
                                   : {3'b000, sq_reg};
        end
    end

    assign prod = prod2_reg;
    assign wsq  = wsq_reg;
endmodule
`default_nettype wire

// File: src/sie_merge.sv
// ---------------------------------------------------------------------------
// sie_merge
// Combines lane results into energy and radicand, and forms the pressure.
// ---------------------------------------------------------------------------
`default_nettype none
module sie_merge (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire logic                  valid_in,
    input  wire logic signed [33:0]    psum,
    input  wire logic                  two_d,
    input  wire logic signed [63:0]    prod [sie_pkg::LANES],
    input  wire logic        [66:0]    wsq  [sie_pkg::LANES],
    output logic                       valid_out,
    output logic             [63:0]    radicand,
    output sie_pkg::sie_payload_t      payload
);
    import sie_pkg::*;

    localparam logic signed [66:0] ERND = {{(67 - SHIFT){1'b0}}, {SHIFT{1'b1}}};
    localparam logic signed [66:0] EMAX = {20'h00000, {47{1'b1}}};
    localparam logic signed [66:0] EMIN = {{20{1'b1}}, 47'd0};

    // pressure path
    logic        [32:0] pmag_reg;
    logic               pneg_b_reg, ptwo_b_reg, pneg_c_reg, ptwo_c_reg, pneg_d_reg;
    logic        [51:0] pp_lo_reg;
    logic        [50:0] pp_hi_reg;
    logic        [31:0] phalf_reg;
    logic        [31:0] q_reg;
    logic signed [31:0] pres_e_reg, pres_f_reg;
    logic        [68:0] q3_sum;
    logic        [33:0] pabs;

    // energy and radicand path
    logic signed [64:0] epair_reg [3];
    logic        [67:0] wpair_reg [3];
    logic signed [66:0] etot_reg;
    logic        [68:0] vtot_reg;
    logic signed [66:0] etr;
    logic signed [47:0] energy_reg;
    logic        [63:0] rad_reg;
    logic               sat_reg;
    logic               vb_reg, vc_reg, vd_reg;

    assign pabs   = psum[33] ? 34'(-psum) : 34'(psum);
    assign q3_sum = {1'b0, pp_hi_reg, 17'd0} + {17'd0, pp_lo_reg};
    assign etr    = (etot_reg + (etot_reg[66] ? ERND : 67'sd0)) >>> SHIFT;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pmag_reg   <= pabs[32:0];
            pneg_b_reg <= psum[33];
            ptwo_b_reg <= two_d;
            pp_lo_reg  <= pmag_reg[16:0] * RECIP3;
            pp_hi_reg  <= pmag_reg[32:17] * RECIP3;
            phalf_reg  <= pmag_reg[32:1];
            pneg_c_reg <= pneg_b_reg;
            ptwo_c_reg <= ptwo_b_reg;
            q_reg      <= ptwo_c_reg ? phalf_reg : q3_sum[67:36];
            pneg_d_reg <= pneg_c_reg;
            if (pneg_d_reg) begin
                pres_e_reg <= (q_reg == 32'h80000000) ? 32'sh7FFFFFFF : $signed(q_reg);
            end else begin
                pres_e_reg <= $signed(-q_reg);
            end
            pres_f_reg <= pres_e_reg;

            for (int j = 0; j < 3; j++) begin
                epair_reg[j] <= 65'(prod[2*j]) + 65'(prod[2*j+1]);
                wpair_reg[j] <= 68'(wsq[2*j]) + 68'(wsq[2*j+1]);
            end
            etot_reg <= 67'(epair_reg[0]) + 67'(epair_reg[1]) + 67'(epair_reg[2]);
            vtot_reg <= 69'(wpair_reg[0]) + 69'(wpair_reg[1]) + 69'(wpair_reg[2]);
            if (etr > EMAX) begin
                energy_reg <= EMAX[47:0];
            end else if (etr < EMIN) begin
                energy_reg <= EMIN[47:0];
            end else begin
                energy_reg <= etr[47:0];
            end
            rad_reg <= vtot_reg[64:1];
            sat_reg <= |vtot_reg[68:65];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= valid_in;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    assign valid_out        = vd_reg;
    assign radicand         = rad_reg;
    assign payload.pressure = pres_f_reg;
    assign payload.energy   = energy_reg;
    assign payload.sat      = sat_reg;
endmodule
`default_nettype wire

// File: src/sie_sqrt.sv
// ---------------------------------------------------------------------------
// sie_sqrt
// Pipelined floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module sie_sqrt (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire logic                  valid_in,
    input  wire logic [63:0]           radicand,
    input  wire sie_pkg::sie_payload_t payload_in,
    output logic                       valid_out,
    output logic [31:0]                root,
    output sie_pkg::sie_payload_t      payload_out
);
    import sie_pkg::*;

    logic [63:0]  rad_reg  [ROOT_BITS];
    logic [33:0]  rem_reg  [ROOT_BITS];
    logic [31:0]  root_reg [ROOT_BITS];
    sie_payload_t pay_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] v_reg;

    logic [63:0] rad_in  [ROOT_BITS];
    logic [33:0] rem_in  [ROOT_BITS];
    logic [31:0] root_in [ROOT_BITS];
    logic [33:0] cur     [ROOT_BITS];
    logic [33:0] trial   [ROOT_BITS];
    logic        ge      [ROOT_BITS];

    always_comb begin
        for (int k = 0; k < ROOT_BITS; k++) begin
            rad_in[k]  = (k == 0) ? radicand : rad_reg[(k == 0) ? 0 : k - 1];
            rem_in[k]  = (k == 0) ? 34'd0 : rem_reg[(k == 0) ? 0 : k - 1];
            root_in[k] = (k == 0) ? 32'd0 : root_reg[(k == 0) ? 0 : k - 1];
            cur[k]     = {rem_in[k][31:0], rad_in[k][63:62]};
            trial[k]   = {root_in[k], 2'b01};
            ge[k]      = cur[k] >= trial[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < ROOT_BITS; k++) begin
                rad_reg[k]  <= {rad_in[k][61:0], 2'b00};
                rem_reg[k]  <= ge[k] ? cur[k] - trial[k] : cur[k];
                root_reg[k] <= {root_in[k][30:0], ge[k]};
                pay_reg[k]  <= (k == 0) ? payload_in : pay_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[ROOT_BITS-2:0], valid_in};
        end
    end

    assign valid_out   = v_reg[ROOT_BITS-1];
    assign payload_out = pay_reg[ROOT_BITS-1];
    assign root        = pay_reg[ROOT_BITS-1].sat ? 32'hFFFFFFFF : root_reg[ROOT_BITS-1];
endmodule
`default_nettype wire

// File: src/stress_invariant_evaluator.sv
// ---------------------------------------------------------------------------
// stress_invariant_evaluator
// Pressure, strain energy and von Mises stress of one node per request.
// ---------------------------------------------------------------------------
// One request is accepted per cycle while the pipeline is not halted. Six
// component lanes form the stress-strain products and weighted squares in
// parallel, a merge stage sums them and finishes pressure and energy, and a
// 32-stage square root pipeline (one root bit per stage) gives the von Mises
// stress. The pipeline only halts when its last stage and the output
// register both hold unclaimed results.
`default_nettype none
module stress_invariant_evaluator (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_stress_0,
    input  wire logic signed [31:0] s_stress_1,
    input  wire logic signed [31:0] s_stress_2,
    input  wire logic signed [31:0] s_stress_3,
    input  wire logic signed [31:0] s_stress_4,
    input  wire logic signed [31:0] s_stress_5,
    input  wire logic signed [31:0] s_strain_0,
    input  wire logic signed [31:0] s_strain_1,
    input  wire logic signed [31:0] s_strain_2,
    input  wire logic signed [31:0] s_strain_3,
    input  wire logic signed [31:0] s_strain_4,
    input  wire logic signed [31:0] s_strain_5,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pressure,
    output logic signed [47:0]      m_strain_energy,
    output logic        [31:0]      m_von_mises
);
    import sie_pkg::*;

    logic [1:0] dim_reg;
    logic       two_d;
    logic       adv, out_load;

    logic signed [31:0] st [LANES];
    logic signed [31:0] sn [LANES];

    logic signed [31:0] stress_reg [LANES];
    logic signed [31:0] strain_reg [LANES];
    logic signed [32:0] sqop_reg   [LANES];
    logic signed [33:0] psum_reg;
    logic               two_d_reg;
    logic               va_reg, vb_reg, vc_reg;

    logic signed [63:0] prod [LANES];
    logic        [66:0] wsq  [LANES];

    logic               f_valid, z_valid;
    logic [63:0]        f_rad;
    sie_payload_t       f_pay, z_pay;
    logic [31:0]        z_root;

    logic               m_valid_reg;
    logic signed [31:0] m_pressure_reg;
    logic signed [47:0] m_energy_reg;
    logic        [31:0] m_vm_reg;

    assign st = '{s_stress_0, s_stress_1, s_stress_2, s_stress_3, s_stress_4, s_stress_5};
    assign sn = '{s_strain_0, s_strain_1, s_strain_2, s_strain_3, s_strain_4, s_strain_5};

    assign two_d     = (dim_reg == DIM_2D);
    assign cfg_ready = 1'b1;
    assign out_load  = !m_valid_reg || m_ready;
    assign adv       = out_load || !z_valid;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dim_reg <= cfg_data;
        end
    end

    // operand selection
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < LANES; i++) begin
                stress_reg[i] <= st[i];
                strain_reg[i] <= (two_d && i >= 3) ? 32'sd0 : sn[i];
            end
            sqop_reg[0] <= 33'(st[0]) - 33'(st[1]);
            sqop_reg[1] <= two_d ? 33'(st[0]) : 33'(st[1]) - 33'(st[2]);
            sqop_reg[2] <= two_d ? 33'(st[1]) : 33'(st[2]) - 33'(st[0]);
            sqop_reg[3] <= two_d ? 33'(st[2]) : 33'(st[3]);
            sqop_reg[4] <= two_d ? 33'sd0 : 33'(st[4]);
            sqop_reg[5] <= two_d ? 33'sd0 : 33'(st[5]);
            psum_reg    <= 34'(st[0]) + 34'(st[1]) + (two_d ? 34'sd0 : 34'(st[2]));
            two_d_reg   <= two_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sie_lane u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .stress (stress_reg[g]),
            .strain (strain_reg[g]),
            .sq_op  (sqop_reg[g]),
            .heavy  (g >= 3),
            .prod   (prod[g]),
            .wsq    (wsq[g])
        );
    end

    sie_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .valid_in  (vc_reg),
        .psum      (psum_reg),
        .two_d     (two_d_reg),
        .prod      (prod),
        .wsq       (wsq),
        .valid_out (f_valid),
        .radicand  (f_rad),
        .payload   (f_pay)
    );

    sie_sqrt u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .valid_in    (f_valid),
        .radicand    (f_rad),
        .payload_in  (f_pay),
        .valid_out   (z_valid),
        .root        (z_root),
        .payload_out (z_pay)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= z_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pressure_reg <= z_pay.pressure;
            m_energy_reg   <= z_pay.energy;
            m_vm_reg       <= z_root;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pressure      = m_pressure_reg;
    assign m_strain_energy = m_energy_reg;
    assign m_von_mises     = m_vm_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready) else $error("input stalled with empty output");
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> dim_reg == $past(cfg_data)) else $error("dimension write lost");
    a_pressure_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_pressure_reg != 32'sh80000000) else $error("pressure out of range");
`endif
endmodule
`default_nettype wire

// File: tb/stress_invariant_evaluator_test.sv
// ---------------------------------------------------------------------------
// stress_invariant_evaluator_test
// Streams stress and strain requests through the evaluator under random
// sender bursts and receiver stalls, predicts pressure, strain energy and
// von Mises stress for each accepted request and compares results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module stress_invariant_evaluator_test;
    import sie_pkg::*;

    typedef struct {
        logic signed [31:0] pressure;
        logic signed [47:0] energy;
        logic        [31:0] vm;
    } invariants_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_stress [6];
    logic signed [31:0] s_strain [6];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pressure;
    logic signed [47:0] m_strain_energy;
    logic [31:0] m_von_mises;

    logic [1:0] dim_reg = DIM_RESET;
    invariants_t expected_q[$];
    int errors = 0;
    longint cycles = 0;
    int stall_mode = 0;

    initial begin
        for (int i = 0; i < 6; i++) begin
            s_stress[i] = '0;
            s_strain[i] = '0;
        end
    end

    stress_invariant_evaluator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_stress_0(s_stress[0]), .s_stress_1(s_stress[1]),
        .s_stress_2(s_stress[2]), .s_stress_3(s_stress[3]),
        .s_stress_4(s_stress[4]), .s_stress_5(s_stress[5]),
        .s_strain_0(s_strain[0]), .s_strain_1(s_strain[1]),
        .s_strain_2(s_strain[2]), .s_strain_3(s_strain[3]),
        .s_strain_4(s_strain[4]), .s_strain_5(s_strain[5]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pressure(m_pressure), .m_strain_energy(m_strain_energy),
        .m_von_mises(m_von_mises)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[stress_invariant_evaluator] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] floor_root(logic [65:0] v);
        logic [65:0] res;
        logic [65:0] bitv;
        res = '0;
        bitv = 66'd1 << 64;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (res > 66'hFFFFFFFF) return 32'hFFFFFFFF;
        return res[31:0];
    endfunction

    function automatic invariants_t predict_invariants(logic [1:0] dim,
            logic signed [31:0] st[6], logic signed [31:0] sn[6]);
        invariants_t r;
        logic signed [35:0] sum;
        logic signed [35:0] quo;
        logic signed [67:0] dot;
        logic signed [67:0] en;
        logic signed [33:0] d;
        logic [69:0] rad;
        logic two_d;
        int n;
        int nd;
        two_d = (dim == DIM_2D);
        n = two_d ? 3 : 6;
        nd = two_d ? 2 : 3;
        sum = 0;
        for (int i = 0; i < nd; i++) sum += st[i];
        quo = sum / nd;
        quo = -quo;
        r.pressure = (quo > 36'sd2147483647) ? 32'h7FFFFFFF : quo[31:0];
        dot = 0;
        for (int i = 0; i < n; i++) dot += 68'(st[i]) * 68'(sn[i]);
        // truncation toward zero of dot / 2^17
        en = (dot < 0) ? -((-dot) >>> SHIFT) : (dot >>> SHIFT);
        if (en > 68'sd140737488355327) en = 68'sd140737488355327;
        if (en < -68'sd140737488355328) en = -68'sd140737488355328;
        r.energy = en[47:0];
        rad = 0;
        if (two_d) begin
            d = 34'(st[0]) - 34'(st[1]);
            rad = 70'(d * d) + 70'(64'(st[0]) * st[0]) + 70'(64'(st[1]) * st[1])
                + 70'd6 * 70'(64'(st[2]) * st[2]);
        end else begin
            d = 34'(st[0]) - 34'(st[1]); rad += 70'(d * d);
            d = 34'(st[1]) - 34'(st[2]); rad += 70'(d * d);
            d = 34'(st[2]) - 34'(st[0]); rad += 70'(d * d);
            for (int i = 3; i < 6; i++) rad += 70'd6 * 70'(64'(st[i]) * st[i]);
        end
        rad = rad >> 1;
        r.vm = (rad[69:64] != 0) ? 32'hFFFFFFFF : floor_root({2'b00, rad[63:0]});
        return r;
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= cycles[3];
        endcase
    end

    always @(posedge aclk) begin
        invariants_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result p=%h", $time, m_pressure);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_pressure !== e.pressure) begin
                    $display("%0t pressure exp %h got %h", $time, e.pressure, m_pressure);
                    errors++;
                end
                if (m_strain_energy !== e.energy) begin
                    $display("%0t energy exp %h got %h", $time, e.energy, m_strain_energy);
                    errors++;
                end
                if (m_von_mises !== e.vm) begin
                    $display("%0t von_mises exp %h got %h", $time, e.vm, m_von_mises);
                    errors++;
                end
            end
        end
    end

    task automatic send_node(logic signed [31:0] st[6], logic signed [31:0] sn[6]);
        for (int i = 0; i < 6; i++) begin
            s_stress[i] <= st[i];
            s_strain[i] <= sn[i];
        end
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_q.insert(expected_q.size(), predict_invariants(dim_reg, st, sn));
        // random gap between bursts
        if ($urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_dimension(logic [1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dim_reg = v;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] st[6];
        logic signed [31:0] sn[6];
        logic [31:0] pat[6];
        pat = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h00010000,
                32'h55555555};
        foreach (pat[k]) begin
            for (int i = 0; i < 6; i++) begin
                st[i] = pat[k];
                sn[i] = pat[(k + i) % 6];
            end
            send_node(st, sn);
        end
        // mean of exactly -2^31 saturates pressure
        for (int i = 0; i < 6; i++) begin
            st[i] = 32'h80000000;
            sn[i] = 32'h80000000;
        end
        send_node(st, sn);
        st[0] = 32'h7FFFFFFF; st[1] = 32'h80000000; st[2] = 32'h7FFFFFFF;
        sn[0] = 32'h7FFFFFFF; sn[1] = 32'h7FFFFFFF; sn[2] = 32'h7FFFFFFF;
        send_node(st, sn);
        st = '{-7, 3, 1, -1, 2, -5};
        sn = '{1, -1, 1, -1, 1, -1};
        send_node(st, sn);
    endtask

    task automatic test_random(int count);
        logic signed [31:0] st[6];
        logic signed [31:0] sn[6];
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) stall_mode = $urandom_range(0, 3);
            for (int i = 0; i < 6; i++) begin
                st[i] = rand_value();
                sn[i] = rand_value();
            end
            send_node(st, sn);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        stall_mode = 1;
        test_extremes();
        test_random(200);
        write_dimension(DIM_2D);
        test_extremes();
        test_random(300);
        write_dimension(2'd0);
        test_extremes();
        test_random(150);
        write_dimension(2'd1);
        test_random(150);
        write_dimension(2'd3);
        test_random(150);
        write_dimension(DIM_2D);
        stall_mode = 0;
        test_random(250);
        drain();
        if (errors == 0) begin
            $display("[stress_invariant_evaluator] OK");
        end else begin
            $display("[stress_invariant_evaluator] ERROR");
        end
        $finish;
    end
endmodule

// File: stress_invariant_evaluator.f
src/sie_pkg.sv
src/sie_lane.sv
src/sie_merge.sv
src/sie_sqrt.sv
src/stress_invariant_evaluator.sv
tb/stress_invariant_evaluator_test.sv
